// File: src/morphing_unison_pm_oscillator_assert.svh
// Assertion macros used by the oscillator top level.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef MORPHING_UNISON_PM_OSCILLATOR_ASSERT_SVH
`define MORPHING_UNISON_PM_OSCILLATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define MUPO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MUPO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MUPO_ASSERT(lbl, prop, msg)
`define MUPO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/mupo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mupo_pkg;

    localparam int MAX_VOICES       = 16;
    localparam int PHASE_BITS       = 24;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int VOICE_W    = 4;
    localparam int STEP_W     = 24;
    localparam int SAMPLE_W   = 16;
    localparam int SHAPE_W    = 13;
    localparam int LEVEL_W    = 16;
    localparam int OPF_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_FREQ = 2'd2;

    localparam logic [SHAPE_W-1:0] SHAPE_RESET   = 13'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 16'd32768;
    localparam logic [OPF_W-1:0]   OP_FREQ_RESET = 16'd256;

    localparam int VIDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SINE_IDX_W  = $clog2(SINE_TABLE_DEPTH);
    // Sine magnitudes run from 0 to 32768 inclusive.
    localparam int SINE_W      = 17;
    // Wave values span -32768 .. 32768.
    localparam int WAVE_W      = 18;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [STEP_W-1:0]  freq_step;
        logic [STEP_W-1:0]  mod_phase;
        logic               last_in;
    } mupo_in_t;

    typedef struct packed {
        logic [VOICE_W-1:0]         voice_out;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_out;
    } mupo_out_t;

    // One voice whose final phase is known, waiting for wave synthesis.
    typedef struct packed {
        logic [VOICE_W-1:0]    voice;
        logic [PHASE_BITS-1:0] phase;
        logic                  last;
    } mupo_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mupo_q_status_t;

    typedef logic [SINE_W-1:0] mupo_sine_rom_t [0:SINE_TABLE_DEPTH];

    function automatic longint unsigned series_div(input longint unsigned t, input int n);
        longint unsigned q;
        case (n)
            1:       q = t / 6;
            2:       q = t / 20;
            3:       q = t / 42;
            4:       q = t / 72;
            5:       q = t / 110;
            6:       q = t / 156;
            default: q = t / 210;
        endcase
        return q;
    endfunction

    // Taylor series for sin(pi/2 * k / depth) in Q30, rounded to Q15.
    function automatic logic [SINE_W-1:0] sine_entry(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (PI_HALF_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = series_div((term * x2) >> 30, n);
            if (n[0])
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum + 16384) >>> 15;
        if (sum > 32768)
        begin
            sum = 32768;
        end
        return SINE_W'(sum);
    endfunction

    function automatic mupo_sine_rom_t build_sine_rom();
        mupo_sine_rom_t rom;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam mupo_sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// File: src/mupo_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mupo_front import mupo_pkg::*; (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mupo_in_t       in_data,
    input  wire logic [OPF_W-1:0] op_freq,
    output logic                push,
    output mupo_job_t           push_data,
    input  wire mupo_q_status_t q_status
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_ACC
    } front_state_t;

    localparam int PROD_W = STEP_W + OPF_W;
    localparam int UP_SH  = (PHASE_BITS >= STEP_W) ? PHASE_BITS - STEP_W : 0;
    localparam int DN_SH  = (PHASE_BITS < STEP_W) ? STEP_W - PHASE_BITS : 0;

    front_state_t          state_reg;
    mupo_in_t              item_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PHASE_BITS-1:0] phase_reg [MAX_VOICES];

    logic [VIDX_W-1:0]     vidx;
    logic [PHASE_BITS-1:0] inc;
    logic [PHASE_BITS-1:0] modp;
    logic [PHASE_BITS-1:0] acc;

    // Voice numbers fold onto the available accumulators.
    function automatic logic [VIDX_W-1:0] voice_slot(input logic [VOICE_W-1:0] v);
        logic [VIDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << VOICE_W); i++)
        begin
            if (v == VOICE_W'(i))
            begin
                r = VIDX_W'(i % MAX_VOICES);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        vidx = voice_slot(item_reg.voice);
        inc  = PHASE_BITS'(((64'(prod_reg) >> 8) << UP_SH) >> DN_SH);
        modp = PHASE_BITS'((64'(item_reg.mod_phase) << UP_SH) >> DN_SH);
        acc  = phase_reg[vidx] + inc;
        in_ready = (state_reg == F_IDLE);
        push     = (state_reg == F_ACC) && !q_status.full;
        push_data.voice = item_reg.voice;
        push_data.phase = acc + modp;
        push_data.last  = item_reg.last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            for (int i = 0; i < MAX_VOICES; i++)
            begin
                phase_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    state_reg <= F_ACC;
                end
                F_ACC:
                begin
                    if (!q_status.full)
                    begin
                        phase_reg[vidx] <= acc;
                        state_reg       <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= PROD_W'(item_reg.freq_step) * PROD_W'(op_freq);
        end
    end

endmodule

`default_nettype wire

// File: src/mupo_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mupo_fifo import mupo_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire mupo_job_t push_data,
    input  wire logic      pop,
    output mupo_job_t      head,
    output mupo_q_status_t status
);

    mupo_job_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        head         = entry_reg[rd_ptr_reg];
        status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
        status.empty = (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/mupo_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mupo_back import mupo_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    output logic                    pop,
    input  wire mupo_job_t          head,
    input  wire mupo_q_status_t     q_status,
    input  wire logic [SHAPE_W-1:0] shape,
    input  wire logic [LEVEL_W-1:0] level,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mupo_out_t               out_data
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_MIX,
        B_SCALE,
        B_OUT
    } back_state_t;

    localparam logic [2:0] W_SINE     = 3'd0;
    localparam logic [2:0] W_TRIANGLE = 3'd1;
    localparam logic [2:0] W_SAW      = 3'd2;
    localparam logic [2:0] W_SQUARE   = 3'd3;

    localparam int R_W      = PHASE_BITS - 2;
    localparam int RS_W     = R_W + SINE_IDX_W;
    localparam int MIXACC_W = WAVE_W + 12;
    localparam int SCALED_W = WAVE_W + LEVEL_W + 1;

    localparam logic signed [WAVE_W-1:0] ONE_Q15   = WAVE_W'(32768);
    localparam logic signed [WAVE_W-1:0] PULSE_LOW = WAVE_W'(-6554);
    localparam logic signed [WAVE_W-1:0] TRI_TOP   = WAVE_W'(98304);
    localparam logic [SHAPE_W-1:0]       SHAPE_MAX = SHAPE_W'(4096);

    back_state_t                  state_reg;
    mupo_job_t                    job_reg;
    logic [SINE_W-1:0]            sine_q_reg;
    logic signed [WAVE_W-1:0]     mix_reg;
    logic signed [SCALED_W-1:0]   scaled_reg;
    logic                         out_valid_reg;
    mupo_out_t                    out_reg;

    logic [R_W-1:0]               head_r;
    logic [RS_W-1:0]              r_scaled;
    logic [SINE_IDX_W-1:0]        sine_idx;
    logic [SINE_ADDR_W-1:0]       rom_addr;
    logic [15:0]                  f;
    logic signed [WAVE_W-1:0]     fs;
    logic signed [WAVE_W-1:0]     sine_val;
    logic [SHAPE_W-1:0]           s_clamp;
    logic [2:0]                   i0;
    logic [9:0]                   wt;
    logic signed [WAVE_W-1:0]     wave_a;
    logic signed [WAVE_W-1:0]     wave_b;
    logic signed [MIXACC_W-1:0]   mix_acc;
    logic signed [SCALED_W-1:0]   rounded;
    logic signed [SAMPLE_W-1:0]   sat_sample;
    logic                         out_free;

    function automatic logic signed [WAVE_W-1:0] wave_value(
        input logic [2:0]               sel,
        input logic signed [WAVE_W-1:0] fv,
        input logic signed [WAVE_W-1:0] sv
    );
        logic signed [WAVE_W-1:0] r;
        case (sel)
            W_SINE:     r = sv;
            W_TRIANGLE: r = (fv <= ONE_Q15) ? (fv <<< 1) - ONE_Q15 : TRI_TOP - (fv <<< 1);
            W_SAW:      r = fv - ONE_Q15;
            W_SQUARE:   r = (fv < ONE_Q15) ? ONE_Q15 : -ONE_Q15;
            default:    r = (fv < ONE_Q15) ? ONE_Q15 : PULSE_LOW;
        endcase
        return r;
    endfunction

    always_comb
    begin
        // Quarter-wave index; the mirrored quadrants read the table backwards.
        head_r   = head.phase[R_W-1:0];
        r_scaled = RS_W'(head_r) * RS_W'(SINE_TABLE_DEPTH);
        sine_idx = SINE_IDX_W'(r_scaled >> R_W);
        rom_addr = head.phase[PHASE_BITS-2]
                 ? SINE_ADDR_W'(SINE_TABLE_DEPTH) - SINE_ADDR_W'(sine_idx)
                 : SINE_ADDR_W'(sine_idx);

        f        = job_reg.phase[PHASE_BITS-1 -: 16];
        fs       = $signed(WAVE_W'(f));
        sine_val = job_reg.phase[PHASE_BITS-1] ? -$signed(WAVE_W'(sine_q_reg))
                                               : $signed(WAVE_W'(sine_q_reg));
        s_clamp  = (shape > SHAPE_MAX) ? SHAPE_MAX : shape;
        i0       = s_clamp[12:10];
        wt       = s_clamp[9:0];
        wave_a   = wave_value(i0, fs, sine_val);
        wave_b   = wave_value(i0 + 3'd1, fs, sine_val);
        // a*(1024-w) + b*w written as 1024*a + w*(b-a), rounded half up.
        mix_acc  = (MIXACC_W'(wave_a) <<< 10)
                 + (MIXACC_W'(wave_b) - MIXACC_W'(wave_a)) * $signed(MIXACC_W'(wt))
                 + MIXACC_W'(512);

        rounded  = (scaled_reg + SCALED_W'(16384)) >>> 15;
        if (rounded > SCALED_W'(32767))
        begin
            sat_sample = 16'sd32767;
        end
        else if (rounded < -SCALED_W'(32768))
        begin
            sat_sample = -16'sd32768;
        end
        else
        begin
            sat_sample = SAMPLE_W'(rounded);
        end

        out_free  = !out_valid_reg || out_ready;
        pop       = (state_reg == B_IDLE) && !q_status.empty;
        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new sample may replace the one being transferred in the same cycle.
            if ((state_reg == B_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        state_reg <= B_MIX;
                    end
                end
                B_MIX:
                begin
                    state_reg <= B_SCALE;
                end
                B_SCALE:
                begin
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg    <= head;
            sine_q_reg <= SINE_ROM[rom_addr];
        end
        if (state_reg == B_MIX)
        begin
            mix_reg <= WAVE_W'(mix_acc >>> 10);
        end
        if (state_reg == B_SCALE)
        begin
            scaled_reg <= SCALED_W'(mix_reg) * $signed(SCALED_W'(level));
        end
        if ((state_reg == B_OUT) && out_free)
        begin
            out_reg.voice_out <= job_reg.voice;
            out_reg.sample    <= sat_sample;
            out_reg.last_out  <= job_reg.last;
        end
    end

endmodule

`default_nettype wire

// File: src/morphing_unison_pm_oscillator.sv
`timescale 1ns / 1ps
`default_nettype none

// Morphing unison phase-modulation oscillator. Each input transfer names a
// voice, its phase step and a modulation phase; one output transfer carries
// that voice's Q1.15 sample and the copied last flag. The front end works
// through capture, step times op_freq multiply, and accumulator update with
// queue write in turn, and the back end through queue read with the sine
// table lookup, crossfade multiply, level multiply, and rounding and
// saturation into the output register. The back end's four-step sequence
// sets the sustained rate; each half finishes one item before taking the
// next. A two-entry queue between the halves and the output register let
// either side stall alone. The shape, level and op_freq registers should
// only be written while no item is in flight.

module morphing_unison_pm_oscillator import mupo_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire mupo_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output mupo_out_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "morphing_unison_pm_oscillator_assert.svh"

    logic [SHAPE_W-1:0] shape_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [OPF_W-1:0]   op_freq_reg;

    logic           push;
    mupo_job_t      push_data;
    logic           pop;
    mupo_job_t      head;
    mupo_q_status_t q_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg   <= SHAPE_RESET;
            level_reg   <= LEVEL_RESET;
            op_freq_reg <= OP_FREQ_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SHAPE:   shape_reg   <= cfg_data[SHAPE_W-1:0];
                CFG_LEVEL:   level_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_OP_FREQ: op_freq_reg <= cfg_data[OPF_W-1:0];
                default:     ;
            endcase
        end
    end

    mupo_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .op_freq   (op_freq_reg),
        .push      (push),
        .push_data (push_data),
        .q_status  (q_status)
    );

    mupo_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    mupo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status),
        .shape     (shape_reg),
        .level     (level_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `MUPO_ASSERT(a_push_room, push |-> !q_status.full, "queue written while full")
    `MUPO_ASSERT(a_pop_data, pop |-> !q_status.empty, "queue read while empty")
    `MUPO_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "front took two items at once")

endmodule

`default_nettype wire

// File: dv/morphing_unison_pm_oscillator_tb.sv
`timescale 1ns / 1ps

module morphing_unison_pm_oscillator_tb;
    import mupo_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 200;
    localparam int SHAPE_FULL    = 4096;
    localparam int UNITY         = 32768;
    localparam int PULSE_FLOOR   = -6554;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {WAVE_SINE, WAVE_TRIANGLE, WAVE_SAW, WAVE_SQUARE, WAVE_PULSE} wave_e;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    mupo_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    mupo_out_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    morphing_unison_pm_oscillator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the oscillator state and registers.
    int                    sine_quarter [0:SINE_TABLE_DEPTH];
    logic [PHASE_BITS-1:0] osc_phase [MAX_VOICES];
    logic [SHAPE_W-1:0]    shape_mirror = SHAPE_RESET;
    logic [LEVEL_W-1:0]    level_mirror = LEVEL_RESET;
    logic [OPF_W-1:0]      opf_mirror   = OP_FREQ_RESET;

    mupo_in_t  voice_requests [$];
    mupo_out_t expected_samples [$];

    int  n_queued   = 0;
    int  n_sent     = 0;
    int  n_checked  = 0;
    int  n_settings = 0;
    int  n_holds    = 0;
    int  errors     = 0;
    bit  in_took    = 1'b0;
    bit  hold_req   = 1'b0;
    int  burst_left = 0;
    int  gap_left   = 0;
    int  hold_left  = 0;
    int  rx_left    = 0;
    int  rx_tick    = 0;
    rx_mode_e rx_mode = RX_OPEN;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("morphing_unison_pm_oscillator: mismatch");
        $finish;
    end

    // Quarter-wave sine magnitude by an eight-term Taylor series in Q30.
    function automatic int quarter_sine(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (HALF_PI_Q30 * k) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        return (acc > UNITY) ? UNITY : int'(acc);
    endfunction

    function automatic int wave_at(wave_e sel, logic [PHASE_BITS-1:0] ph);
        int         f;
        int         idx;
        int         mag;
        logic [1:0] quad;
        f    = ph[PHASE_BITS-1 -: 16];
        quad = ph[PHASE_BITS-1 -: 2];
        idx  = (ph[PHASE_BITS-3:0] * longint'(SINE_TABLE_DEPTH)) >> (PHASE_BITS - 2);
        if (idx >= SINE_TABLE_DEPTH)
        begin
            idx = SINE_TABLE_DEPTH - 1;
        end
        case (sel)
            WAVE_SINE:
            begin
                mag = quad[0] ? sine_quarter[SINE_TABLE_DEPTH - idx] : sine_quarter[idx];
                return quad[1] ? -mag : mag;
            end
            WAVE_TRIANGLE: return (f <= UNITY) ? 2 * f - UNITY : 3 * UNITY - 2 * f;
            WAVE_SAW:      return f - UNITY;
            WAVE_SQUARE:   return (f < UNITY) ? UNITY : -UNITY;
            default:       return (f < UNITY) ? UNITY : PULSE_FLOOR;
        endcase
    endfunction

    function automatic int morph_mix(logic [PHASE_BITS-1:0] ph);
        int     s;
        int     pair;
        int     wt;
        int     a;
        longint blend;
        s    = (shape_mirror > SHAPE_FULL) ? SHAPE_FULL : int'(shape_mirror);
        pair = s >> 10;
        wt   = s & 1023;
        a    = wave_at(wave_e'(pair), ph);
        if (pair >= WAVE_PULSE || wt == 0)
        begin
            return a;
        end
        // Offset keeps the sum positive so the shift rounds half up.
        blend = longint'(a) * (1024 - wt) + longint'(wave_at(wave_e'(pair + 1), ph)) * wt
                + longint'(UNITY) * 1024 + 512;
        return int'(blend >>> 10) - UNITY;
    endfunction

    function automatic mupo_out_t synth_sample(mupo_in_t item);
        mupo_out_t             res;
        logic [PHASE_BITS-1:0] step_inc;
        logic [PHASE_BITS-1:0] ph;
        longint                prod;
        int                    slot;
        slot           = item.voice % MAX_VOICES;
        step_inc       = PHASE_BITS'((64'(item.freq_step) * opf_mirror) >> 8);
        osc_phase[slot] = osc_phase[slot] + step_inc;
        ph             = osc_phase[slot] + item.mod_phase;
        prod = longint'(morph_mix(ph)) * longint'(level_mirror) + 16384;
        prod = prod >>> 15;
        if (prod > 32767)
        begin
            prod = 32767;
        end
        if (prod < -32768)
        begin
            prod = -32768;
        end
        res.voice_out = item.voice;
        res.sample    = SAMPLE_W'(prod);
        res.last_out  = item.last_in;
        return res;
    endfunction

    // Results are checked before the same edge's input is predicted.
    always @(posedge clk)
    begin : scoreboard
        mupo_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("unexpected sample transfer: voice %0d sample %0d",
                       out_data.voice_out, out_data.sample);
                errors++;
            end
            else
            begin
                want = expected_samples.pop_front();
                n_checked++;
                if (out_data.voice_out !== want.voice_out)
                begin
                    $error("voice_out: expected %0d, got %0d", want.voice_out, out_data.voice_out);
                    errors++;
                end
                if (out_data.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", want.sample, out_data.sample);
                    errors++;
                end
                if (out_data.last_out !== want.last_out)
                begin
                    $error("last_out: expected %0d, got %0d", want.last_out, out_data.last_out);
                    errors++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            expected_samples.push_back(synth_sample(in_data));
            n_sent++;
            in_took = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            in_took = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (voice_requests.size() > 0)
            begin
                in_data  <= voice_requests.pop_front();
                in_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                n_holds++;
                out_ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_e'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 160);
                end
                rx_left--;
                case (rx_mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= $urandom_range(0, 1);
                    RX_SPARSE: out_ready <= (rx_tick % 5 == 0);
                    default:   out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic queue_voice(int v, int step, int mod, bit last);
        mupo_in_t it;
        it.voice     = VOICE_W'(v);
        it.freq_step = STEP_W'(step);
        it.mod_phase = STEP_W'(mod);
        it.last_in   = last;
        voice_requests.push_back(it);
        n_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SHAPE:   shape_mirror = val[SHAPE_W-1:0];
            CFG_LEVEL:   level_mirror = val;
            CFG_OP_FREQ: opf_mirror   = val;
            default:     ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(int shape_v, int level_v, int opf_v);
        write_reg(CFG_SHAPE, CFG_DATA_W'(shape_v));
        write_reg(CFG_LEVEL, CFG_DATA_W'(level_v));
        write_reg(CFG_OP_FREQ, CFG_DATA_W'(opf_v));
        n_settings++;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (n_sent != n_queued || expected_samples.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_phase(bit with_hold);
        int budget;
        int n;
        int base;
        int shape_v;
        int level_v;
        int opf_v;
        case ($urandom_range(0, 5))
            0:       shape_v = 0;
            1:       shape_v = SHAPE_FULL;
            2:       shape_v = $urandom_range(SHAPE_FULL + 1, 8191);
            3:       shape_v = 1024 * $urandom_range(0, 4);
            default: shape_v = $urandom_range(0, SHAPE_FULL);
        endcase
        case ($urandom_range(0, 4))
            0:       level_v = 0;
            1:       level_v = UNITY;
            2:       level_v = 65535;
            default: level_v = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 4))
            0:       opf_v = 0;
            1:       opf_v = 65535;
            2:       opf_v = 256;
            default: opf_v = $urandom_range(0, 65535);
        endcase
        apply_settings(shape_v, level_v, opf_v);
        budget = PHASE_ITEMS;
        while (budget > 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                // A frame: voices in order, last flag on the final one.
                n    = $urandom_range(1, MAX_VOICES);
                base = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 24'hFFFFFF)
                                                   : $urandom_range(0, 24'h00FFFF);
                for (int v = 0; v < n; v++)
                begin
                    queue_voice(v, base + $urandom_range(0, 255), $urandom_range(0, 24'hFFFFFF),
                                v == n - 1);
                end
                budget -= n;
            end
            else
            begin
                queue_voice($urandom_range(0, 15), $urandom_range(0, 24'hFFFFFF),
                            $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1));
                budget--;
            end
        end
        if (with_hold)
        begin
            @(posedge clk);
            hold_req = 1'b1;
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SHAPE;
        cfg_data  = '0;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            sine_quarter[k] = quarter_sine(k);
        end
        for (int v = 0; v < MAX_VOICES; v++)
        begin
            osc_phase[v] = '0;
        end
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: sine at unity gain, quadrant edges.
        queue_voice(0, 0, 0, 0);
        queue_voice(1, 0, 24'h3FFFFF, 0);
        queue_voice(1, 0, 24'h400000, 0);
        queue_voice(1, 0, 24'h800000, 0);
        queue_voice(1, 0, 24'hC00000, 0);
        queue_voice(1, 0, 24'hFFFFFF, 1);
        queue_voice(15, 24'hFFFFFF, 24'h123456, 1);
        queue_voice(15, 24'hFFFFFF, 0, 0);
        wait_drained();

        // Pulse at maximum gain; the largest step wraps the accumulator many times.
        apply_settings(SHAPE_FULL, 65535, 65535);
        queue_voice(2, 24'hFFFFFF, 0, 0);
        queue_voice(4, 0, 24'h7FFFFF, 0);
        queue_voice(4, 0, 24'h800000, 1);
        wait_drained();

        // Square saturates at both rails.
        apply_settings(3 * 1024, 65535, 256);
        queue_voice(4, 0, 24'h7FFFFF, 0);
        queue_voice(4, 0, 24'h800000, 0);
        wait_drained();

        apply_settings(1024, UNITY, 256);
        queue_voice(5, 0, 24'h800000, 0);
        queue_voice(5, 0, 24'h800100, 0);
        queue_voice(5, 0, 0, 1);
        wait_drained();

        apply_settings(2048, UNITY, 256);
        queue_voice(6, 0, 0, 0);
        queue_voice(6, 0, 24'hFFFFFF, 1);
        wait_drained();

        // Crossfade just short of halfway between triangle and saw.
        apply_settings(1535, 40000, 1);
        queue_voice(7, 24'h800000, 24'h200000, 0);
        queue_voice(7, 24'hFFFFFF, 24'hABCDEF, 1);
        wait_drained();

        // Shape above one clamps to the pulse; a write to the spare index is dropped.
        apply_settings(8191, UNITY, 0);
        write_reg(CFG_SPARE, 16'hFFFF);
        @(posedge clk);
        queue_voice(8, 24'hFFFFFF, 24'h555555, 0);
        queue_voice(9, 24'hAAAAAA, 24'hAAAAAA, 1);
        wait_drained();

        apply_settings(0, 0, 256);
        queue_voice(10, 24'h345678, 24'h400000, 1);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            run_random_phase(ph == 3 || ph == 7);
        end

        $display("Checked %0d samples from %0d voice transfers over %0d register settings.",
                 n_checked, n_sent, n_settings);
        $display("Output held off %0d times for %0d cycles while input kept offering.",
                 n_holds, HOLD_CYCLES);
        if (errors == 0)
        begin
            $display("morphing_unison_pm_oscillator: match");
        end
        else
        begin
            $display("morphing_unison_pm_oscillator: mismatch");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/mupo_pkg.sv
src/mupo_front.sv
src/mupo_fifo.sv
src/mupo_back.sv
src/morphing_unison_pm_oscillator.sv
dv/morphing_unison_pm_oscillator_tb.sv
